### src/avcc_header_to_annexb_defines.svh
`ifndef AVCC_HEADER_TO_ANNEXB_DEFINES_SVH
`define AVCC_HEADER_TO_ANNEXB_DEFINES_SVH

// same-cycle implication check
`define AVCCAB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("avccab check failed");

// next-cycle implication check
`define AVCCAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("avccab check failed");

`endif

### src/avccab_pkg.sv
package avccab_pkg;

  localparam int unsigned LEN_W  = 25;
  localparam int unsigned SIZE_W = 3;
  localparam int unsigned IDX_W  = 3;

  localparam logic [7:0] SPS_COUNT_MASK  = 8'h1F;
  localparam logic [7:0] SIZE_MASK       = 8'h03;
  localparam logic [7:0] START_CODE_ZERO = 8'h00;
  localparam logic [7:0] START_CODE_LAST = 8'h01;

  localparam logic KIND_STREAM  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // work handed from the parser to the emitter
  typedef struct packed {
    logic                 start;
    logic                 pay;
    logic                 sum;
    logic [7:0]           data;
    logic [LEN_W-1:0]     hlen;
    logic [SIZE_W-1:0]    lsize;
    logic                 trunc;
  } cmd_t;

endpackage

### src/avccab_front.sv
module avccab_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output avccab_pkg::cmd_t   cmd
);

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_LEN_HI  = 6'b000010,
    PH_LEN_LO  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_COUNT   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [avccab_pkg::IDX_W-1:0]       hidx_r, hidx_nxt;
  logic [7:0]                         entries_r, entries_nxt;
  logic                               pps_r, pps_nxt;
  logic [7:0]                         len_hi_r, len_hi_nxt;
  logic [15:0]                        pay_left_r, pay_left_nxt;
  logic [avccab_pkg::SIZE_W-1:0]      size_r, size_nxt;
  logic [avccab_pkg::LEN_W-1:0]       bytes_r, bytes_nxt;
  logic [7:0]                         entries_dec;
  phase_t                             finish_phase;
  logic                               accept;
  logic                               emit_start;
  logic                               emit_pay;

  assign in_ready = cmd_ready;
  assign accept   = in_valid & in_ready;

  assign entries_dec  = entries_r - 8'd1;
  assign finish_phase = (entries_dec != 8'd0) ? PH_LEN_HI : (pps_r ? PH_DONE : PH_COUNT);

  always_comb begin
    phase_nxt    = phase_r;
    hidx_nxt     = hidx_r;
    entries_nxt  = entries_r;
    pps_nxt      = pps_r;
    len_hi_nxt   = len_hi_r;
    pay_left_nxt = pay_left_r;
    size_nxt     = size_r;
    emit_start   = 1'b0;
    emit_pay     = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        if (hidx_r == avccab_pkg::IDX_W'(4)) begin
          size_nxt = {1'b0, in_byte[1:0] & avccab_pkg::SIZE_MASK[1:0]} + 3'd1;
        end
        if (hidx_r == avccab_pkg::IDX_W'(5)) begin
          entries_nxt = in_byte & avccab_pkg::SPS_COUNT_MASK;
          pps_nxt     = 1'b0;
          phase_nxt   = ((in_byte & avccab_pkg::SPS_COUNT_MASK) != 8'd0) ? PH_LEN_HI : PH_COUNT;
          hidx_nxt    = '0;
        end else begin
          hidx_nxt = hidx_r + avccab_pkg::IDX_W'(1);
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = in_byte;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        emit_start   = 1'b1;
        pay_left_nxt = {len_hi_r, in_byte};
        if ({len_hi_r, in_byte} != 16'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          entries_nxt = entries_dec;
          phase_nxt   = finish_phase;
        end
      end
      PH_PAYLOAD: begin
        emit_pay     = 1'b1;
        pay_left_nxt = pay_left_r - 16'd1;
        if (pay_left_r == 16'd1) begin
          entries_nxt = entries_dec;
          phase_nxt   = finish_phase;
        end
      end
      PH_COUNT: begin
        entries_nxt = in_byte;
        pps_nxt     = 1'b1;
        phase_nxt   = (in_byte != 8'd0) ? PH_LEN_HI : PH_DONE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bytes_nxt = bytes_r;
    if (emit_start) begin
      bytes_nxt = bytes_r + avccab_pkg::LEN_W'(4);
    end else if (emit_pay) begin
      bytes_nxt = bytes_r + avccab_pkg::LEN_W'(1);
    end
  end

  always_comb begin
    cmd.start = emit_start;
    cmd.pay   = emit_pay;
    cmd.sum   = in_last;
    cmd.data  = in_byte;
    cmd.hlen  = bytes_nxt;
    cmd.lsize = size_nxt;
    cmd.trunc = !((phase_nxt == PH_COUNT) || (phase_nxt == PH_DONE));
  end

  assign cmd_valid = accept & (emit_start | emit_pay | in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hidx_r     <= '0;
      entries_r  <= '0;
      pps_r      <= 1'b0;
      len_hi_r   <= '0;
      pay_left_r <= '0;
      size_r     <= avccab_pkg::SIZE_W'(1);
      bytes_r    <= '0;
    end else if (accept) begin
      if (in_last) begin
        // record done, start over
        phase_r    <= PH_HEADER;
        hidx_r     <= '0;
        entries_r  <= '0;
        pps_r      <= 1'b0;
        len_hi_r   <= '0;
        pay_left_r <= '0;
        size_r     <= avccab_pkg::SIZE_W'(1);
        bytes_r    <= '0;
      end else begin
        phase_r    <= phase_nxt;
        hidx_r     <= hidx_nxt;
        entries_r  <= entries_nxt;
        pps_r      <= pps_nxt;
        len_hi_r   <= len_hi_nxt;
        pay_left_r <= pay_left_nxt;
        size_r     <= size_nxt;
        bytes_r    <= bytes_nxt;
      end
    end
  end

endmodule

### src/avccab_cmdq.sv
module avccab_cmdq #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  avccab_pkg::cmd_t  push_cmd,
  output logic              not_full,
  input  logic              pop,
  output logic              head_valid,
  output avccab_pkg::cmd_t  head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  avccab_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign not_full   = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push & not_full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/avccab_back.sv
module avccab_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  avccab_pkg::cmd_t                cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic [avccab_pkg::LEN_W-1:0]    out_header_length,
  output logic [avccab_pkg::SIZE_W-1:0]   out_length_size,
  output logic                            out_truncated
);

  logic [2:0]                        step_r, step_nxt;
  logic                              out_valid_r;
  logic                              kind_r, kind_nxt;
  logic [7:0]                        byte_r, byte_nxt;
  logic                              last_r, last_nxt;
  logic [avccab_pkg::LEN_W-1:0]      hlen_r, hlen_nxt;
  logic [avccab_pkg::SIZE_W-1:0]     lsize_r, lsize_nxt;
  logic                              trunc_r, trunc_nxt;
  logic [2:0]                        total;
  logic                              load;

  assign load  = cmd_valid & (!out_valid_r | out_ready);
  assign total = (cmd.start ? 3'd4 : 3'd0) + {2'b0, cmd.pay} + {2'b0, cmd.sum};

  always_comb begin
    kind_nxt  = avccab_pkg::KIND_STREAM;
    byte_nxt  = avccab_pkg::START_CODE_ZERO;
    hlen_nxt  = '0;
    lsize_nxt = '0;
    trunc_nxt = 1'b0;
    last_nxt  = (step_r == total - 3'd1);
    if (cmd.start && step_r < 3'd4) begin
      byte_nxt = (step_r == 3'd3) ? avccab_pkg::START_CODE_LAST : avccab_pkg::START_CODE_ZERO;
    end else if (cmd.pay && step_r == 3'd0) begin
      byte_nxt = cmd.data;
    end else begin
      kind_nxt  = avccab_pkg::KIND_SUMMARY;
      hlen_nxt  = cmd.hlen;
      lsize_nxt = cmd.lsize;
      trunc_nxt = cmd.trunc;
    end
    step_nxt = step_r;
    if (load) begin
      step_nxt = last_nxt ? 3'd0 : step_r + 3'd1;
    end
  end

  assign cmd_pop = load & last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      byte_r  <= byte_nxt;
      last_r  <= last_nxt;
      hlen_r  <= hlen_nxt;
      lsize_r <= lsize_nxt;
      trunc_r <= trunc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_byte          = byte_r;
  assign out_last          = last_r;
  assign out_header_length = hlen_r;
  assign out_length_size   = lsize_r;
  assign out_truncated     = trunc_r;

endmodule

### src/avcc_header_to_annexb.sv
// Converts an AVC decoder configuration record, one byte per request, into the
// Annex B parameter set stream: each SPS and PPS entry comes out as 00 00 00 01
// followed by its payload, and the byte flagged in_last adds a summary result
// with the total output length, the NAL length size and a truncation flag.
// Header bytes, the PPS count byte and a length field's high byte produce no
// output; a payload byte produces one result and is taken every cycle while the
// command queue has room. A length field's low byte produces four start code
// results, which the emitter drives one per cycle through its output register
// while out_ready is high; the command queue, two entries by default, still
// takes the next request at once; the one after waits until the start code pops.

`include "avcc_header_to_annexb_defines.svh"

module avcc_header_to_annexb #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic [avccab_pkg::LEN_W-1:0]    out_header_length,
  output logic [avccab_pkg::SIZE_W-1:0]   out_length_size,
  output logic                            out_truncated
);

  avccab_pkg::cmd_t  front_cmd;
  avccab_pkg::cmd_t  head_cmd;
  logic              front_valid;
  logic              q_not_full;
  logic              head_valid;
  logic              head_pop;
  logic              sum_out;
  logic              stream_out;

  avccab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd_valid (front_valid),
    .cmd_ready (q_not_full),
    .cmd       (front_cmd)
  );

  avccab_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_valid),
    .push_cmd   (front_cmd),
    .not_full   (q_not_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  avccab_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (head_valid),
    .cmd               (head_cmd),
    .cmd_pop           (head_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_header_length (out_header_length),
    .out_length_size   (out_length_size),
    .out_truncated     (out_truncated)
  );

  assign sum_out    = out_valid && (out_kind == avccab_pkg::KIND_SUMMARY);
  assign stream_out = out_valid && (out_kind == avccab_pkg::KIND_STREAM);

  `AVCCAB_ASSERT_NOW(a_sum_is_last, sum_out, out_last)
  `AVCCAB_ASSERT_NOW(a_sum_size_set, sum_out, out_length_size != '0)
  `AVCCAB_ASSERT_NOW(a_stream_no_len, stream_out, out_header_length == '0)
  `AVCCAB_ASSERT_NOW(a_stream_clean, stream_out, out_length_size == '0 && !out_truncated)
  `AVCCAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

endmodule
